### rtl/core/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

  localparam int DEPTH_DEFAULT      = 256;
  localparam int COORD_BITS_DEFAULT = 16;

  localparam int CMD_W    = 3;
  localparam int FIELD_W  = 16;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_POP      = 3'd2,
    CMD_CONTAINS = 3'd3,
    CMD_READ     = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  localparam logic [FIELD_W-1:0] FIELD_MINUS_ONE = '1;

endpackage

### rtl/core/clt_pair_ram.sv
`timescale 1ns / 1ps

module clt_pair_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/coordinate_list_table_core.sv
`timescale 1ns / 1ps
// channel   | handshake            | payload
// ----------+----------------------+-----------------------------------------------
// request   | in_valid / in_ready  | cmd, coord_x, coord_y, index
// result    | out_valid / out_ready| status, found, read_x, read_y, entry_count
//
// append and pop go from idle straight to the done state, read passes through
// a read state, contains scans the stored entries in order, and remove scans and
// then shifts the later entries down; the single read port of the pair memory
// scans or shifts one entry per cycle.
// rst is synchronous and clears the count, the state machine and out_valid;
// the pair memory is not cleared.
// a result waiting on out_ready does not block the next request from being
// taken and worked on; only posting its result waits for the output register.

module coordinate_list_table_core
  import clt_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [FIELD_W-1:0]  coord_x,
  input  logic [FIELD_W-1:0]  coord_y,
  input  logic [INDEX_W-1:0]  index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic                found,
  output logic [FIELD_W-1:0]  read_x,
  output logic [FIELD_W-1:0]  read_y,
  output logic [COUNT_W-1:0]  entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int CB = COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_t;

  state_t              state;
  logic [CMD_W-1:0]    cmd_q;
  logic [CB-1:0]       x_q;
  logic [CB-1:0]       y_q;
  logic [CW-1:0]       count;
  logic [CW-1:0]       ptr;
  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic [FIELD_W-1:0]  res_x;
  logic [FIELD_W-1:0]  res_y;

  logic                accept;
  logic [31:0]         x32;
  logic [31:0]         y32;
  logic [CB-1:0]       x_in;
  logic [CB-1:0]       y_in;
  logic [31:0]         cnt32;
  logic [31:0]         idx32;
  logic                full;
  logic                idx_ok;
  logic [CW-1:0]       ptr_p1;
  logic [CW-1:0]       ptr_p2;
  logic                match;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [2*CB-1:0]     ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [2*CB-1:0]     ram_rdata;
  logic [FIELD_W-1:0]  rd_x16;
  logic [FIELD_W-1:0]  rd_y16;
  logic                post;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // sign-extend the 16-bit inputs, then cut to the stored width
  assign x32  = {{16{coord_x[FIELD_W-1]}}, coord_x};
  assign y32  = {{16{coord_y[FIELD_W-1]}}, coord_y};
  assign x_in = x32[CB-1:0];
  assign y_in = y32[CB-1:0];

  assign cnt32  = 32'(count);
  assign idx32  = 32'(index);
  assign full   = (cnt32 >= 32'(DEPTH));
  assign idx_ok = (idx32 < cnt32);
  assign ptr_p1 = ptr + CW'(1);
  assign ptr_p2 = ptr + CW'(2);
  assign match  = (ram_rdata == {x_q, y_q});
  assign post   = !out_valid || out_ready;

  // stored width back to 16 bits with sign extension
  for (genvar g = 0; g < FIELD_W; g++) begin : g_ext
    if (g < CB) begin : g_bit
      assign rd_x16[g] = ram_rdata[CB + g];
      assign rd_y16[g] = ram_rdata[g];
    end else begin : g_sign
      assign rd_x16[g] = ram_rdata[2*CB-1];
      assign rd_y16[g] = ram_rdata[CB-1];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = {x_in, y_in};
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        ram_we    = accept && (cmd == CMD_APPEND) && !full;
        ram_raddr = (cmd == CMD_READ) ? idx32[AW-1:0] : '0;
      end
      S_SCAN: begin
        ram_raddr = ptr_p1[AW-1:0];
      end
      S_SHIFT: begin
        ram_we    = (ptr < count);
        ram_waddr = ptr[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = ptr_p2[AW-1:0];
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  clt_pair_ram #(
    .DEPTH(DEPTH),
    .WIDTH(2 * CB),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= cmd;
            x_q        <= x_in;
            y_q        <= y_in;
            ptr        <= '0;
            res_status <= ST_OK;
            res_found  <= 1'b0;
            res_x      <= '0;
            res_y      <= '0;
            state      <= S_DONE;
            case (cmd)
              CMD_APPEND: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              CMD_REMOVE, CMD_CONTAINS: begin
                if (count == '0) begin
                  res_status <= ST_NOT_FOUND;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_POP: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  count <= count - CW'(1);
                end
              end
              CMD_READ: begin
                if (idx_ok) begin
                  state <= S_READ;
                end else begin
                  res_status <= ST_RANGE;
                  res_x      <= FIELD_MINUS_ONE;
                  res_y      <= FIELD_MINUS_ONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            res_found <= 1'b1;
            if (cmd_q == CMD_REMOVE) begin
              count <= count - CW'(1);
              state <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end else if (ptr_p1 == count) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            ptr <= ptr_p1;
          end
        end
        S_SHIFT: begin
          if (ptr < count) begin
            ptr <= ptr_p1;
          end else begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          res_x <= rd_x16;
          res_y <= rd_y16;
          state <= S_DONE;
        end
        S_DONE: begin
          if (post) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            found       <= res_found;
            read_x      <= res_x;
            read_y      <= res_y;
            entry_count <= cnt32[COUNT_W-1:0];
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt32 <= 32'(DEPTH))
    else $error("entry count above capacity");

  a_shift_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (ptr <= count))
    else $error("shift pointer past end of list");

  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_APPEND) && !full) |=> (count == $past(count) + CW'(1)))
    else $error("append did not grow the list");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_POP) && (count == '0)) |=> (count == '0))
    else $error("pop on empty list changed the count");

  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (ptr < count))
    else $error("scan pointer outside stored entries");

endmodule
